[sv/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Command codes, payload types and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
    localparam int FRACTION_BITS = 8;
    localparam int WORD_W        = 32;
    // widened dividend: a shifted left by FRACTION_BITS
    localparam int DIVD_W        = WORD_W + FRACTION_BITS;
    // one pipeline stage per quotient bit group
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES    = (DIVD_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int DIVQ_W        = DIV_STAGES * DIV_BITS_PER_STAGE;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,  CMD_SUB  = 4'd1,  CMD_MUL = 4'd2,  CMD_DIV = 4'd3,
        CMD_GT   = 4'd4,  CMD_LT   = 4'd5,  CMD_GE  = 4'd6,  CMD_LE  = 4'd7,
        CMD_EQ   = 4'd8,  CMD_NE   = 4'd9,  CMD_INC = 4'd10, CMD_DEC = 4'd11,
        CMD_MIN  = 4'd12, CMD_MAX  = 4'd13, CMD_FROM_INT = 4'd14,
        CMD_TO_INT = 4'd15
    } cmd_t;

    typedef struct packed {
        logic [3:0]               cmd;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic                     compare_true;
        logic                     divide_error;
    } rsp_t;

    // divider stage state
    typedef struct packed {
        logic              valid;
        logic [DIVQ_W-1:0] quo;   // dividend bits shift out, quotient bits shift in
        logic [WORD_W:0]   rem;
        logic [WORD_W-1:0] dvs;
        logic              neg;
        rsp_t              fast;  // result for non-divide commands
        logic              is_div;
    } div_stage_t;
endpackage
`default_nettype wire

[sv/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Q-format signed ALU, one request per cycle through a stalling pipeline.
// ----------------------------------------------------------------------------
// Every command passes the front stage, the DIV_STAGES divider stages and the output register.
// Throughput: one request per cycle; latency set by the pipelined divider chain.
// A stall on m_ready holds the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; data is not cleared.
`default_nettype none
module fixed_point_alu (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire fpa_pkg::req_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output fpa_pkg::rsp_t       m_data
);
    localparam int W  = fpa_pkg::WORD_W;
    localparam int N  = fpa_pkg::DIV_STAGES;
    localparam int FB = fpa_pkg::FRACTION_BITS;

    logic adv;
    fpa_pkg::div_stage_t st [N+1];
    logic signed [63:0] prod [N+1];
    logic               is_mul [N+1];
    fpa_pkg::rsp_t out_reg, out_next;
    logic          out_valid_reg;
    logic [W-1:0]  q;

    // advance when the output register is empty or being drained
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    fpa_front u_front (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(s_valid),
        .req(s_data), .out_st(st[0]), .prod_out(prod[0]), .is_mul_out(is_mul[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_div
        fpa_div_stage u_stage (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_st(st[g]), .out_st(st[g+1])
        );
        logic signed [63:0] prod_reg;
        logic               mul_reg;
        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg <= prod[g];
                mul_reg  <= is_mul[g];
            end
        end
        assign prod[g+1]   = prod_reg;
        assign is_mul[g+1] = mul_reg;
    end

    always_comb begin
        q        = st[N].quo[W-1:0];
        out_next = st[N].fast;
        if (st[N].is_div) begin
            out_next.value_out = st[N].neg ? W'(-q) : q;
        end else if (is_mul[N]) begin
            out_next.value_out = W'(prod[N] >>> FB);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= st[N].valid;
        end
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped during stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline stalled with empty output");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.compare_true && m_data.divide_error))
        else $error("compare and divide flags both set");
endmodule
`default_nettype wire

[sv/fpa_front.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU front stage
// Single-cycle commands, comparisons, 64-bit product and divider set-up.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire fpa_pkg::req_t     req,
    output fpa_pkg::div_stage_t    out_st,
    output logic signed [63:0]     prod_out,
    output logic                   is_mul_out
);
    localparam int W  = fpa_pkg::WORD_W;
    localparam int FB = fpa_pkg::FRACTION_BITS;

    fpa_pkg::div_stage_t st_reg, st_next;
    logic signed [63:0]  prod_reg;
    logic                is_mul_reg;

    logic signed [W-1:0] a, b;
    logic                lt, eq;
    fpa_pkg::rsp_t       r;
    logic [W-1:0]        abs_a, abs_b;
    logic [fpa_pkg::DIVD_W-1:0] dvd;

    always_comb begin
        a  = req.operand_a;
        b  = req.operand_b;
        lt = a < b;
        eq = a == b;
        r  = '0;
        case (req.cmd)
            fpa_pkg::CMD_ADD:      r.value_out = a + b;
            fpa_pkg::CMD_SUB:      r.value_out = a - b;
            fpa_pkg::CMD_GT:       r.compare_true = !lt && !eq;
            fpa_pkg::CMD_LT:       r.compare_true = lt;
            fpa_pkg::CMD_GE:       r.compare_true = !lt;
            fpa_pkg::CMD_LE:       r.compare_true = lt || eq;
            fpa_pkg::CMD_EQ:       r.compare_true = eq;
            fpa_pkg::CMD_NE:       r.compare_true = !eq;
            fpa_pkg::CMD_INC:      r.value_out = a + W'(1);
            fpa_pkg::CMD_DEC:      r.value_out = a - W'(1);
            fpa_pkg::CMD_MIN:      r.value_out = lt ? a : b;
            fpa_pkg::CMD_MAX:      r.value_out = (!lt && !eq) ? a : b;
            fpa_pkg::CMD_FROM_INT: r.value_out = a <<< FB;
            fpa_pkg::CMD_TO_INT:   r.value_out = a >>> FB;
            fpa_pkg::CMD_DIV:      r.divide_error = (b == '0);
            default:               r = '0;
        endcase
        abs_a = a[W-1] ? W'(-a) : a;
        abs_b = b[W-1] ? W'(-b) : b;
        dvd   = {abs_a, {FB{1'b0}}};
        st_next        = '0;
        st_next.valid  = in_valid;
        st_next.quo    = fpa_pkg::DIVQ_W'(dvd);
        st_next.dvs    = abs_b;
        st_next.neg    = a[W-1] ^ b[W-1];
        st_next.fast   = r;
        st_next.is_div = (req.cmd == fpa_pkg::CMD_DIV) && (b != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (adv) begin
            st_reg <= st_next;
        end
        if (adv) begin
            prod_reg   <= 64'(a) * 64'(b);
            is_mul_reg <= req.cmd == fpa_pkg::CMD_MUL;
        end
    end

    assign out_st     = st_reg;
    assign prod_out   = prod_reg;
    assign is_mul_out = is_mul_reg;
endmodule
`default_nettype wire

[sv/fpa_div_stage.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU divider stage
// Restoring division, DIV_BITS_PER_STAGE quotient bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                adv,
    input  wire fpa_pkg::div_stage_t in_st,
    output fpa_pkg::div_stage_t      out_st
);
    localparam int W = fpa_pkg::WORD_W;

    fpa_pkg::div_stage_t st_reg, st_next;
    logic [W:0]  rem, diff;
    logic [fpa_pkg::DIVQ_W-1:0] quo;

    always_comb begin
        st_next = in_st;
        rem = in_st.rem;
        quo = in_st.quo;
        for (int i = 0; i < fpa_pkg::DIV_BITS_PER_STAGE; i++) begin
            rem  = {rem[W-1:0], quo[fpa_pkg::DIVQ_W-1]};
            diff = rem - {1'b0, in_st.dvs};
            quo  = {quo[fpa_pkg::DIVQ_W-2:0], !diff[W]};
            if (!diff[W]) begin
                rem = diff;
            end
        end
        st_next.rem = rem;
        st_next.quo = quo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (adv) begin
            st_reg <= st_next;
        end
    end

    assign out_st = st_reg;
endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Directed table of corner requests, then random requests, with every result
// checked against a behavioural model of the ALU under random sender bursts
// and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    localparam int N_RANDOM  = 1200;
    localparam int LATENCY   = fpa_pkg::DIV_STAGES + 2;
    localparam int N_TABLE   = 24;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    fpa_pkg::req_t  s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    fpa_pkg::rsp_t  m_data;

    fpa_pkg::rsp_t  pending_rsp[$];
    int    mismatches = 0;
    bit    sending_done = 1'b0;

    fixed_point_alu dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic fpa_pkg::rsp_t alu_result(fpa_pkg::req_t r);
        fpa_pkg::rsp_t      res;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        a = r.operand_a;
        b = r.operand_b;
        res = '0;
        case (fpa_pkg::cmd_t'(r.cmd))
            fpa_pkg::CMD_ADD: res.value_out = a + b;
            fpa_pkg::CMD_SUB: res.value_out = a - b;
            fpa_pkg::CMD_MUL: begin
                wide = 64'(a) * 64'(b);
                wide = wide >>> fpa_pkg::FRACTION_BITS;
                res.value_out = wide[31:0];
            end
            fpa_pkg::CMD_DIV: begin
                if (b == 0) begin
                    res.divide_error = 1'b1;
                end else begin
                    num  = 64'(a) <<< fpa_pkg::FRACTION_BITS;
                    wide = num / 64'(b);
                    res.value_out = wide[31:0];
                end
            end
            fpa_pkg::CMD_GT:  res.compare_true = a > b;
            fpa_pkg::CMD_LT:  res.compare_true = a < b;
            fpa_pkg::CMD_GE:  res.compare_true = a >= b;
            fpa_pkg::CMD_LE:  res.compare_true = a <= b;
            fpa_pkg::CMD_EQ:  res.compare_true = a == b;
            fpa_pkg::CMD_NE:  res.compare_true = a != b;
            fpa_pkg::CMD_INC: res.value_out = a + 1;
            fpa_pkg::CMD_DEC: res.value_out = a - 1;
            fpa_pkg::CMD_MIN: res.value_out = (a < b) ? a : b;
            fpa_pkg::CMD_MAX: res.value_out = (a > b) ? a : b;
            fpa_pkg::CMD_FROM_INT: res.value_out = a <<< fpa_pkg::FRACTION_BITS;
            default: res.value_out = a >>> fpa_pkg::FRACTION_BITS;
        endcase
        return res;
    endfunction

    // directed rows; table_rsp is typed in only where table_known is set
    fpa_pkg::req_t  table_req[N_TABLE];
    fpa_pkg::rsp_t  table_rsp[N_TABLE];
    bit    table_known[N_TABLE];

    task automatic add_row(int i, fpa_pkg::cmd_t c, logic [31:0] a, logic [31:0] b,
                           bit known, logic [31:0] v, bit ct, bit de);
        table_req[i] = '{cmd: c, operand_a: a, operand_b: b};
        table_rsp[i] = '{value_out: v, compare_true: ct, divide_error: de};
        table_known[i] = known;
    endtask

    initial begin
        add_row(0,  fpa_pkg::CMD_ADD, 32'h7fffffff, 32'h1, 1, 32'h80000000, 0, 0);
        add_row(1,  fpa_pkg::CMD_SUB, 32'h80000000, 32'h1, 1, 32'h7fffffff, 0, 0);
        add_row(2,  fpa_pkg::CMD_MUL, 32'h100, 32'h100, 1, 32'h100, 0, 0);
        add_row(3,  fpa_pkg::CMD_MUL, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        add_row(4,  fpa_pkg::CMD_MUL, 32'hffffffff, 32'h1, 1, 32'hffffffff, 0, 0);
        add_row(5,  fpa_pkg::CMD_DIV, 32'h1234, 32'h0, 1, 32'h0, 0, 1);
        add_row(6,  fpa_pkg::CMD_DIV, 32'h80000000, 32'hffffffff, 0, 0, 0, 0);
        add_row(7,  fpa_pkg::CMD_DIV, 32'h7fffffff, 32'h1, 0, 0, 0, 0);
        add_row(8,  fpa_pkg::CMD_DIV, 32'hfffffd00, 32'h200, 0, 0, 0, 0);
        add_row(9,  fpa_pkg::CMD_GT,  32'h80000000, 32'h7fffffff, 1, 0, 0, 0);
        add_row(10, fpa_pkg::CMD_LT,  32'h80000000, 32'h7fffffff, 1, 0, 1, 0);
        add_row(11, fpa_pkg::CMD_GE,  32'h5, 32'h5, 1, 0, 1, 0);
        add_row(12, fpa_pkg::CMD_LE,  32'h6, 32'h5, 1, 0, 0, 0);
        add_row(13, fpa_pkg::CMD_EQ,  32'hffffffff, 32'hffffffff, 1, 0, 1, 0);
        add_row(14, fpa_pkg::CMD_NE,  32'hffffffff, 32'hffffffff, 1, 0, 0, 0);
        add_row(15, fpa_pkg::CMD_INC, 32'h7fffffff, 32'h0, 1, 32'h80000000, 0, 0);
        add_row(16, fpa_pkg::CMD_DEC, 32'h80000000, 32'hffffffff, 1, 32'h7fffffff, 0, 0);
        add_row(17, fpa_pkg::CMD_MIN, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 0, 0);
        add_row(18, fpa_pkg::CMD_MAX, 32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 0, 0);
        add_row(19, fpa_pkg::CMD_MIN, 32'h42, 32'h42, 1, 32'h42, 0, 0);
        add_row(20, fpa_pkg::CMD_FROM_INT, 32'h00ffffff, 32'h0, 1, 32'hffffff00, 0, 0);
        add_row(21, fpa_pkg::CMD_FROM_INT, 32'h80000001, 32'h0, 1, 32'h00000100, 0, 0);
        add_row(22, fpa_pkg::CMD_TO_INT, 32'hffffff01, 32'h0, 1, 32'hffffffff, 0, 0);
        add_row(23, fpa_pkg::CMD_TO_INT, 32'h7fffffff, 32'h0, 1, 32'h007fffff, 0, 0);
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'(int'($urandom_range(0, 1024)) - 512);
            3: return 32'h0;
            4: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // hold valid until the request is taken; drop it for a gap between bursts
    task automatic send_request(fpa_pkg::req_t r, ref int burst_left);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // record expectation at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_rsp.push_back(alu_result(s_data));
        end
    end

    initial begin
        int   burst_left;
        fpa_pkg::req_t r;
        burst_left = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_TABLE; i++) begin
            if (table_known[i] && table_rsp[i] !== alu_result(table_req[i])) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %h, model gives %h",
                             i, table_rsp[i], alu_result(table_req[i]));
            end
            send_request(table_req[i], burst_left);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            r.cmd       = $urandom_range(0, 15);
            r.operand_a = rand_operand();
            r.operand_b = rand_operand();
            send_request(r, burst_left);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver: random spells with m_ready open (two times in three) or stalled
    initial begin
        int spell;
        @(posedge aresetn);
        forever begin
            spell = $urandom_range(1, 30);
            m_ready <= ($urandom_range(0, 2) != 0);
            repeat (spell) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        fpa_pkg::rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (m_data !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected val=%h cmp=%b err=%b,",
                                  " got val=%h cmp=%b err=%b"},
                                 exp_rsp.value_out, exp_rsp.compare_true,
                                 exp_rsp.divide_error, m_data.value_out,
                                 m_data.compare_true, m_data.divide_error);
                end
            end
        end
    end

    initial begin
        wait (sending_done);
        @(posedge aclk);
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (LATENCY * 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
